// ===== src/rsm_pkg.sv =====
// Package for the stream byte reassembler: sizes, input item and admission types.
// No dependencies; imported by every module of the block.
package rsm_pkg;

    // Window depth; the ring slot is the low index bits, so this is a power of two
    localparam int WINDOW = 64;
    localparam int WIN_W  = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int IDX_W  = 32;
    localparam int ROOM_W = 7;
    localparam int BYTE_W = 8;

    // Input stream tdata: byte_index, byte_value, room, one pad bit
    localparam int S_DATA_W = 48;
    // Output stream tdata: out_byte, stream_closed, pending_count
    localparam int M_DATA_W = 16;

    // One input transaction, held while it is worked on
    typedef struct packed {
        logic [IDX_W-1:0]  byte_index;
        logic [BYTE_W-1:0] byte_value;
        logic              has_byte;
        logic              final_byte;
        logic [ROOM_W-1:0] room;
    } item_t;

    // Sequencer state seen by the admission check
    typedef struct packed {
        logic [IDX_W-1:0] next_index;
        logic             end_known;
        logic [IDX_W-1:0] end_index;
    } win_state_t;

    // Admission decision for one item
    typedef struct packed {
        logic             rec_end;
        logic [IDX_W-1:0] end_value;
        logic             keep;
    } adm_t;

endpackage

// ===== src/rsm_store.sv =====
// Byte store of the reassembler: ring memory, one write and one registered read.
// Depends on rsm_pkg.
module rsm_store
(
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [rsm_pkg::WIN_W-1:0]  wr_addr,
    input  logic [rsm_pkg::BYTE_W-1:0] wr_data,
    input  logic [rsm_pkg::WIN_W-1:0]  rd_addr,
    output logic [rsm_pkg::BYTE_W-1:0] rd_data
);
    import rsm_pkg::*;

    logic [BYTE_W-1:0] mem [WINDOW];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== src/rsm_window.sv =====
// Admission check: records the stream end and decides whether a byte falls in the window.
// Depends on rsm_pkg.
module rsm_window
(
    input  rsm_pkg::item_t     item,
    input  rsm_pkg::win_state_t st,
    output rsm_pkg::adm_t      adm
);
    import rsm_pkg::*;

    logic [ROOM_W-1:0] lim;
    logic [IDX_W:0]    end_pos;
    logic [IDX_W:0]    win_top;
    logic [IDX_W-1:0]  offset;
    logic              end_known_new;
    logic [IDX_W-1:0]  end_new;

    // Room clipped to the window depth
    assign lim = (item.room > ROOM_W'(WINDOW)) ? ROOM_W'(WINDOW) : item.room;

    // End position: one past a byte, or the index itself for an empty item
    assign end_pos = {1'b0, item.byte_index} + (IDX_W+1)'(item.has_byte);
    assign win_top = {1'b0, st.next_index} + (IDX_W+1)'(lim);

    assign adm.rec_end = item.final_byte && !st.end_known
                       && (end_pos >= {1'b0, st.next_index})
                       && (end_pos <= win_top) && !end_pos[IDX_W];
    assign adm.end_value = end_pos[IDX_W-1:0];

    assign end_known_new = st.end_known || adm.rec_end;
    assign end_new       = adm.rec_end ? end_pos[IDX_W-1:0] : st.end_index;

    // Byte kept only inside [next, next + lim), below the all-ones index and the end
    assign offset = item.byte_index - st.next_index;
    assign adm.keep = item.has_byte && (item.byte_index >= st.next_index)
                    && (offset < IDX_W'(lim)) && (item.byte_index != '1)
                    && !(end_known_new && (item.byte_index >= end_new));

endmodule

// ===== src/stream_byte_reassembler.sv =====
// Stream byte reassembler: one input transaction at a time; s_tready is high only when idle.
// Steps after the accepting edge: admission, a walk of the valid map over the run of present
// bytes, then for each released byte a store read and an output beat held until m_tready; an
// item releasing nothing offers its empty result after the walk, or straight after admission
// once the stream is closed. A new transaction is taken only after the last result of the
// previous one is handshaked. Reset (rst_n, asynchronous, active low) clears the valid map,
// indices, count and flags.
module stream_byte_reassembler
(
    input  logic                         clk,
    input  logic                         rst_n,
    // byte_index[31:0], byte_value[39:32], room[46:40], zero pad[47]
    input  logic [rsm_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                         s_tuser,   // has_byte
    input  logic                         s_tlast,   // final_byte
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // out_byte[7:0], stream_closed[8], pending_count[15:9]
    output logic [rsm_pkg::M_DATA_W-1:0] m_tdata,
    output logic                         m_tuser,   // out_valid
    output logic                         m_tlast,   // last_of_run
    output logic                         m_tvalid,
    input  logic                         m_tready
);
    import rsm_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EVAL  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_LOAD  = 3'd3;
    localparam logic [2:0] ST_SEND  = 3'd4;
    localparam logic [2:0] ST_EMPTY = 3'd5;

    logic [2:0]        state_reg, state_next;
    item_t             item_reg;
    logic [WINDOW-1:0] valid_reg, valid_next;
    logic [IDX_W-1:0]  next_index_reg, next_index_next;
    logic              end_known_reg, end_known_next;
    logic [IDX_W-1:0]  end_index_reg, end_index_next;
    logic              closed_reg, closed_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  cursor_reg, cursor_next;
    logic [CNT_W-1:0]  run_reg, run_next;
    logic [WIN_W-1:0]  emit_slot_reg, emit_slot_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;

    win_state_t        win_st;
    adm_t              adm;
    logic [WIN_W-1:0]  in_slot;
    logic [WIN_W-1:0]  cur_slot;
    logic              wr_en;
    logic [BYTE_W-1:0] rd_data;
    logic              scan_go;
    logic              out_hs;

    assign s_tready = (state_reg == ST_IDLE);
    assign out_hs   = m_tvalid && m_tready;

    // Capture the accepted transaction
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.byte_index <= s_tdata[IDX_W-1:0];
            item_reg.byte_value <= s_tdata[IDX_W+BYTE_W-1:IDX_W];
            item_reg.room       <= s_tdata[IDX_W+BYTE_W+ROOM_W-1:IDX_W+BYTE_W];
            item_reg.has_byte   <= s_tuser;
            item_reg.final_byte <= s_tlast;
        end
    end

    // Admission check on the held transaction
    assign win_st.next_index = next_index_reg;
    assign win_st.end_known  = end_known_reg;
    assign win_st.end_index  = end_index_reg;

    rsm_window u_window
    (
        .item (item_reg),
        .st   (win_st),
        .adm  (adm)
    );

    assign in_slot  = item_reg.byte_index[WIN_W-1:0];
    assign cur_slot = cursor_reg[WIN_W-1:0];
    assign wr_en    = (state_reg == ST_EVAL) && !closed_reg && adm.keep && !valid_reg[in_slot];

    rsm_store u_store
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (in_slot),
        .wr_data (item_reg.byte_value),
        .rd_addr (emit_slot_reg),
        .rd_data (rd_data)
    );

    // One step of the run walk: slot present, inside the end and the window
    assign scan_go = (run_reg < CNT_W'(WINDOW))
                   && (!end_known_reg || (cursor_reg < end_index_reg))
                   && (cursor_reg != '1) && valid_reg[cur_slot];

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        next_index_next = next_index_reg;
        end_known_next  = end_known_reg;
        end_index_next  = end_index_reg;
        closed_next     = closed_reg;
        count_next      = count_reg;
        cursor_next     = cursor_reg;
        run_next        = run_reg;
        emit_slot_next  = emit_slot_reg;
        rem_next        = rem_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (closed_reg)
                begin
                    state_next = ST_EMPTY;
                end
                else
                begin
                    if (adm.rec_end)
                    begin
                        end_known_next = 1'b1;
                        end_index_next = adm.end_value;
                    end
                    if (wr_en)
                    begin
                        valid_next[in_slot] = 1'b1;
                        count_next          = count_reg + CNT_W'(1);
                    end
                    cursor_next    = next_index_reg;
                    run_next       = '0;
                    emit_slot_next = next_index_reg[WIN_W-1:0];
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_go)
                begin
                    valid_next[cur_slot] = 1'b0;
                    cursor_next          = cursor_reg + IDX_W'(1);
                    run_next             = run_reg + CNT_W'(1);
                end
                else
                begin
                    next_index_next = cursor_reg;
                    if (end_known_reg && (cursor_reg >= end_index_reg))
                    begin
                        // end reached: close and discard whatever is left
                        closed_next = 1'b1;
                        valid_next  = '0;
                        count_next  = '0;
                    end
                    else
                    begin
                        count_next = count_reg - run_reg;
                    end
                    rem_next   = run_reg;
                    state_next = (run_reg == '0) ? ST_EMPTY : ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (out_hs)
                begin
                    emit_slot_next = emit_slot_reg + WIN_W'(1);
                    rem_next       = rem_reg - CNT_W'(1);
                    state_next     = (rem_reg == CNT_W'(1)) ? ST_IDLE : ST_LOAD;
                end
            end
            ST_EMPTY:
            begin
                if (out_hs)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            next_index_reg <= '0;
            end_known_reg  <= 1'b0;
            end_index_reg  <= '0;
            closed_reg     <= 1'b0;
            count_reg      <= '0;
            cursor_reg     <= '0;
            run_reg        <= '0;
            emit_slot_reg  <= '0;
            rem_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            next_index_reg <= next_index_next;
            end_known_reg  <= end_known_next;
            end_index_reg  <= end_index_next;
            closed_reg     <= closed_next;
            count_reg      <= count_next;
            cursor_reg     <= cursor_next;
            run_reg        <= run_next;
            emit_slot_reg  <= emit_slot_next;
            rem_reg        <= rem_next;
        end
    end

    // Result transaction: byte from the store read register, status after the step
    assign m_tvalid = (state_reg == ST_SEND) || (state_reg == ST_EMPTY);
    assign m_tuser  = (state_reg == ST_SEND);
    assign m_tlast  = (state_reg == ST_EMPTY) || (rem_reg == CNT_W'(1));
    assign m_tdata  = {count_reg, closed_reg, (state_reg == ST_SEND) ? rd_data : '0};

endmodule
